// ===== rtl/hdr_tone_map_gamma_defines.svh =====
// Assertion macros used by the tone mapper back end.
`ifndef HDR_TONE_MAP_GAMMA_DEFINES_SVH
`define HDR_TONE_MAP_GAMMA_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HTMG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HTMG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hdrtm_pkg.sv =====
// Shared types and constants of the HDR tone mapper.
`default_nettype none
package hdrtm_pkg;

    // One map pixel as queued between the front and the back end.
    typedef struct packed {
        logic [31:0] peak;
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic        last;
    } hdrtm_item_t;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    localparam int DIV_NUM_W = 96;
    localparam int DIV_DEN_W = 64;
    localparam int DIV_CNT_W = 7;

    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_MAP     = 1'b1;

    // Upper limit of the tone mapped value m, 2.0 in Q.32.
    localparam logic [33:0] M_CAP = 34'h2_0000_0000;

endpackage
`default_nettype wire

// ===== rtl/hdrtm_front.sv =====
// Front end: accepts transfers, tracks the peak and queues map pixels.
`default_nettype none
module hdrtm_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [95:0]          s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 s_tlast,
    input  wire logic                 q_full,
    output logic                      q_push,
    output hdrtm_pkg::hdrtm_item_t    q_item
);

    logic [31:0] peak_reg;
    logic [31:0] peak_next;
    logic [31:0] base;
    logic [31:0] max_r;
    logic [31:0] max_g;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        base      = s_tuser[1] ? 32'd0 : peak_reg;
        max_r     = (s_tdata[31:0] > base) ? s_tdata[31:0] : base;
        max_g     = (s_tdata[63:32] > max_r) ? s_tdata[63:32] : max_r;
        peak_next = (s_tdata[95:64] > max_g) ? s_tdata[95:64] : max_g;
    end

    // Map pixels carry the peak that was current when they arrived.
    assign q_push       = accept && (s_tuser[0] == hdrtm_pkg::FUNC_MAP);
    assign q_item.peak  = peak_reg;
    assign q_item.red   = s_tdata[31:0];
    assign q_item.green = s_tdata[63:32];
    assign q_item.blue  = s_tdata[95:64];
    assign q_item.last  = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= 32'd0;
        end
        else if (accept && (s_tuser[0] == hdrtm_pkg::FUNC_MEASURE))
        begin
            peak_reg <= peak_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hdrtm_fifo.sv =====
// Short pixel queue between the front and the back end.
`default_nettype none
module hdrtm_fifo
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire hdrtm_pkg::hdrtm_item_t push_item,
    input  wire logic                   pop,
    output logic                        full,
    output logic                        valid,
    output hdrtm_pkg::hdrtm_item_t      head
);

    hdrtm_pkg::hdrtm_item_t mem_reg [hdrtm_pkg::QDEPTH];
    logic [hdrtm_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [hdrtm_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [hdrtm_pkg::QPTR_W:0]   count_reg;

    assign full  = (count_reg == (hdrtm_pkg::QPTR_W+1)'(hdrtm_pkg::QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && valid))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && valid))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hdrtm_mul.sv =====
// Shared fixed-point multiplier: floor(a*b/2^32) from four 32x32 partial products.
`default_nettype none
module hdrtm_mul
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             busy,
    output logic             done,
    output logic [63:0]      res
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] prod;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                x = a_reg[31:0];
                y = b_reg[31:0];
            end
            2'd1:
            begin
                x = a_reg[63:32];
                y = b_reg[31:0];
            end
            2'd2:
            begin
                x = a_reg[31:0];
                y = b_reg[63:32];
            end
            default:
            begin
                x = a_reg[63:32];
                y = b_reg[63:32];
            end
        endcase
        prod = x * y;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= a;
                b_reg    <= b;
                step_reg <= 2'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                case (step_reg)
                    2'd0:    acc_reg <= {32'd0, prod[63:32]};
                    2'd1:    acc_reg <= acc_reg + prod;
                    2'd2:    acc_reg <= acc_reg + prod;
                    default: acc_reg <= acc_reg + {prod[31:0], 32'd0};
                endcase
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hdrtm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hdrtm_div
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [hdrtm_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [hdrtm_pkg::DIV_DEN_W-1:0] den,
    output logic                                 busy,
    output logic                                 done,
    output logic [hdrtm_pkg::DIV_NUM_W-1:0]      quot
);

    logic [hdrtm_pkg::DIV_NUM_W-1:0] n_reg;
    logic [hdrtm_pkg::DIV_DEN_W-1:0] d_reg;
    logic [hdrtm_pkg::DIV_DEN_W-1:0] r_reg;
    logic [hdrtm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [hdrtm_pkg::DIV_DEN_W:0]   r_sh;
    logic [hdrtm_pkg::DIV_DEN_W:0]   diff;
    logic                            ge;

    always_comb
    begin
        r_sh = {r_reg, n_reg[hdrtm_pkg::DIV_NUM_W-1]};
        ge   = (r_sh >= {1'b0, d_reg});
        diff = r_sh - {1'b0, d_reg};
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            d_reg    <= '0;
            r_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg    <= num;
                d_reg    <= den;
                r_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // Quotient bits shift in where numerator bits shift out.
                n_reg   <= {n_reg[hdrtm_pkg::DIV_NUM_W-2:0], ge};
                r_reg   <= ge ? diff[hdrtm_pkg::DIV_DEN_W-1:0]
                              : r_sh[hdrtm_pkg::DIV_DEN_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == hdrtm_pkg::DIV_CNT_W'(hdrtm_pkg::DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hdrtm_back.sv =====
// Back end: per-component tone curve, gamma search and byte conversion.
`default_nettype none
`include "hdr_tone_map_gamma_defines.svh"
module hdrtm_back
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire hdrtm_pkg::hdrtm_item_t q_head,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata,
    output logic                        m_tlast
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_COMP  = 5'd1;
    localparam logic [4:0] ST_SQ    = 5'd2;
    localparam logic [4:0] ST_DT    = 5'd3;
    localparam logic [4:0] ST_DS    = 5'd4;
    localparam logic [4:0] ST_M1    = 5'd5;
    localparam logic [4:0] ST_M2    = 5'd6;
    localparam logic [4:0] ST_P2    = 5'd7;
    localparam logic [4:0] ST_P4    = 5'd8;
    localparam logic [4:0] ST_P5    = 5'd9;
    localparam logic [4:0] ST_CAND  = 5'd10;
    localparam logic [4:0] ST_X2    = 5'd11;
    localparam logic [4:0] ST_X4    = 5'd12;
    localparam logic [4:0] ST_X8    = 5'd13;
    localparam logic [4:0] ST_X10   = 5'd14;
    localparam logic [4:0] ST_X11   = 5'd15;
    localparam logic [4:0] ST_BYTE  = 5'd16;
    localparam logic [4:0] ST_NEXTC = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    localparam logic [32:0] ONE = 33'd1 << FRAC_BITS;

    logic [4:0]             state_reg;
    hdrtm_pkg::hdrtm_item_t item_reg;
    logic [1:0]             comp_reg;
    logic [63:0]            k2_reg;
    logic [31:0]            t_reg;
    logic [31:0]            frac_reg;
    logic [32:0]            uh_reg;
    logic [63:0]            prod_reg;
    logic [33:0]            m_reg;
    logic [63:0]            target_reg;
    logic [63:0]            x2_reg;
    logic [32:0]            cand_reg;
    logic [32:0]            v_reg;
    logic [5:0]             bit_reg;
    logic [7:0]             res_reg [3];
    logic                   out_valid_reg;
    logic [23:0]            out_data_reg;
    logic                   out_last_reg;

    logic [31:0]            p;
    logic [32:0]            uh_w;
    logic [64:0]            m_sum;
    logic [33:0]            m_w;
    logic [32:0]            cand_w;
    logic [32:0]            vm1;
    logic [40:0]            scaled;
    logic [7:0]             byte_w;

    logic                   mul_start;
    logic [63:0]            mul_a;
    logic [63:0]            mul_b;
    logic                   mul_busy;
    logic                   mul_done;
    logic [63:0]            mul_res;
    logic                   div_start;
    logic [95:0]            div_num;
    logic [63:0]            div_den;
    logic                   div_busy;
    logic                   div_done;
    logic [95:0]            div_quot;

    hdrtm_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .res   (mul_res)
    );

    hdrtm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        case (comp_reg)
            2'd0:    p = item_reg.red;
            2'd1:    p = item_reg.green;
            default: p = item_reg.blue;
        endcase

        // The integer part of 1 + p/peak^2 is held at 2^32.
        uh_w = (div_quot[95:64] != 32'd0) ? 33'h1_0000_0000
                                          : ({1'b0, div_quot[63:32]} + 33'd1);

        m_sum = {1'b0, prod_reg}
              + (uh_reg[32] ? {1'b0, t_reg, 32'd0} : 65'd0)
              + {33'd0, mul_res[63:32]};
        m_w   = (m_sum > {31'd0, hdrtm_pkg::M_CAP}) ? hdrtm_pkg::M_CAP : m_sum[33:0];

        cand_w = v_reg | (33'd1 << bit_reg);

        // floor((v - 2^-32) * 255), with 255 * x formed as a shift and subtract.
        vm1    = v_reg - 33'd1;
        scaled = {vm1, 8'd0} - {8'd0, vm1};
        if (v_reg == 33'd0)
        begin
            byte_w = 8'd0;
        end
        else if (scaled[40])
        begin
            byte_w = 8'hFF;
        end
        else
        begin
            byte_w = scaled[39:32];
        end
    end

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg) inside
            ST_COMP:
            begin
                if (item_reg.peak != 32'd0)
                begin
                    mul_start = 1'b1;
                    mul_a     = {32'd0, item_reg.peak};
                    mul_b     = {item_reg.peak, 32'd0};
                end
            end
            ST_SQ:
            begin
                if (mul_done)
                begin
                    div_start = 1'b1;
                    div_num   = {32'd0, p, 32'd0};
                    div_den   = {31'd0, ({1'b0, p} + ONE)};
                end
            end
            ST_DT:
            begin
                if (div_done)
                begin
                    div_start = 1'b1;
                    div_num   = {64'd0, p} << (FRAC_BITS + 32);
                    div_den   = k2_reg;
                end
            end
            ST_DS:
            begin
                if (div_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = {32'd0, t_reg};
                    mul_b     = {uh_w[31:0], 32'd0};
                end
            end
            ST_M1:
            begin
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = {32'd0, t_reg};
                    mul_b     = {frac_reg, 32'd0};
                end
            end
            ST_M2:
            begin
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = {30'd0, m_w};
                    mul_b     = {30'd0, m_w};
                end
            end
            ST_P2, ST_X2, ST_X4:
            begin
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = mul_res;
                    mul_b     = mul_res;
                end
            end
            ST_P4:
            begin
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = mul_res;
                    mul_b     = {30'd0, m_reg};
                end
            end
            ST_CAND:
            begin
                mul_start = 1'b1;
                mul_a     = {31'd0, cand_w};
                mul_b     = {31'd0, cand_w};
            end
            ST_X8:
            begin
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = mul_res;
                    mul_b     = x2_reg;
                end
            end
            ST_X10:
            begin
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = mul_res;
                    mul_b     = {31'd0, cand_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            comp_reg      <= 2'd0;
            k2_reg        <= '0;
            t_reg         <= '0;
            frac_reg      <= '0;
            uh_reg        <= '0;
            prod_reg      <= '0;
            m_reg         <= '0;
            target_reg    <= '0;
            x2_reg        <= '0;
            cand_reg      <= '0;
            v_reg         <= '0;
            bit_reg       <= '0;
            res_reg[0]    <= '0;
            res_reg[1]    <= '0;
            res_reg[2]    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // In the output state the refill below takes care of the valid flag.
            if (out_valid_reg && m_tready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg  <= q_head;
                        comp_reg  <= 2'd0;
                        state_reg <= ST_COMP;
                    end
                end
                ST_COMP:
                begin
                    if (item_reg.peak == 32'd0)
                    begin
                        res_reg[comp_reg] <= 8'd0;
                        state_reg         <= ST_NEXTC;
                    end
                    else
                    begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (mul_done)
                    begin
                        k2_reg    <= mul_res;
                        state_reg <= ST_DT;
                    end
                end
                ST_DT:
                begin
                    if (div_done)
                    begin
                        t_reg     <= div_quot[31:0];
                        state_reg <= ST_DS;
                    end
                end
                ST_DS:
                begin
                    if (div_done)
                    begin
                        frac_reg  <= div_quot[31:0];
                        uh_reg    <= uh_w;
                        state_reg <= ST_M1;
                    end
                end
                ST_M1:
                begin
                    if (mul_done)
                    begin
                        prod_reg  <= mul_res;
                        state_reg <= ST_M2;
                    end
                end
                ST_M2:
                begin
                    if (mul_done)
                    begin
                        m_reg     <= m_w;
                        state_reg <= ST_P2;
                    end
                end
                ST_P2:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_P4;
                    end
                end
                ST_P4:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_P5;
                    end
                end
                ST_P5:
                begin
                    if (mul_done)
                    begin
                        target_reg <= mul_res;
                        v_reg      <= '0;
                        bit_reg    <= 6'd32;
                        state_reg  <= ST_CAND;
                    end
                end
                ST_CAND:
                begin
                    cand_reg  <= cand_w;
                    state_reg <= ST_X2;
                end
                ST_X2:
                begin
                    if (mul_done)
                    begin
                        x2_reg    <= mul_res;
                        state_reg <= ST_X4;
                    end
                end
                ST_X4:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_X8;
                    end
                end
                ST_X8:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_X10;
                    end
                end
                ST_X10:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_X11;
                    end
                end
                ST_X11:
                begin
                    if (mul_done)
                    begin
                        // Keep the candidate bit when its eleventh power stays in range.
                        if (mul_res <= target_reg)
                        begin
                            v_reg <= cand_reg;
                        end
                        if (bit_reg == 6'd0)
                        begin
                            state_reg <= ST_BYTE;
                        end
                        else
                        begin
                            bit_reg   <= bit_reg - 6'd1;
                            state_reg <= ST_CAND;
                        end
                    end
                end
                ST_BYTE:
                begin
                    res_reg[comp_reg] <= byte_w;
                    state_reg         <= ST_NEXTC;
                end
                ST_NEXTC:
                begin
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= ST_COMP;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {res_reg[2], res_reg[1], res_reg[0]};
                        out_last_reg  <= item_reg.last;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `HTMG_ASSERT_IMP(a_mul_free, mul_start, !mul_busy, "multiplier started while busy")
    `HTMG_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider started while busy")
    `HTMG_ASSERT_NXT(a_pop_comp, q_pop, state_reg == ST_COMP, "popped pixel not processed")
    `HTMG_ASSERT_IMP(a_m_cap, state_reg == ST_P2, m_reg <= hdrtm_pkg::M_CAP, "m above cap")

endmodule
`default_nettype wire

// ===== rtl/hdr_tone_map_gamma.sv =====
// HDR tone mapper with gamma correction.
//
// Input stream s_*: tdata holds red, green and blue radiance (unsigned fixed point
// with FRAC_BITS fraction bits), tuser holds func (bit 0, 0 = measure, 1 = map)
// and first (bit 1), tlast marks the final pixel of the frame.
// Measure transfers update the stored peak in the cycle they are accepted and
// produce no output; first clears the peak before that transfer's components.
// Map transfers enter a two-entry queue together with the peak of that moment
// and each yields one output transfer on m_*: tdata holds the red, green and
// blue bytes, tlast copies the input tlast.
// Per component a map pixel takes two 96-step serial divisions and a 33-step root
// search with five multiplies per step on the single shared 32x32 multiplier.
// With a zero peak a pixel skips this work and gets zero bytes.
// Measure transfers are taken one per cycle while the queue has room.
// A stalled receiver holds the result in the output register; the back end keeps
// working on the next pixel meanwhile and waits only when it has its result.
// Reset clears the peak to zero, empties the queue and drops any pending result.
`default_nettype none
module hdr_tone_map_gamma
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // red_in, green_in, blue_in
    input  wire logic [1:0]  s_tuser,   // func, first
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // red_out, green_out, blue_out
    output logic             m_tlast
);

    hdrtm_pkg::hdrtm_item_t push_item;
    hdrtm_pkg::hdrtm_item_t head;
    logic                   push;
    logic                   pop;
    logic                   full;
    logic                   valid;

    hdrtm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_item   (push_item)
    );

    hdrtm_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .valid     (valid),
        .head      (head)
    );

    hdrtm_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (valid),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== bench/hdr_tone_map_gamma_tb.sv =====
// Self-checking testbench for the HDR tone mapper with gamma correction.
`timescale 1ns / 100ps
module hdr_tone_map_gamma_tb;

    localparam int FRAC_BITS = 16;
    localparam int STALL_LIMIT = 60000;
    localparam int HOLD_CYCLES = 15000;

    // Predicts the output bytes from the peak tracked over measure transfers.
    class tone_scoreboard;
        logic [31:0] peak;
        logic [24:0] pending_pixels[$];
        int          errors;

        function new();
            peak = '0;
            errors = 0;
        endfunction

        task report(input string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        function longint unsigned mul_q32(longint unsigned a, longint unsigned b);
            longint unsigned ah, al, bh, bl;
            ah = a >> 32;
            al = a & 64'hFFFF_FFFF;
            bh = b >> 32;
            bl = b & 64'hFFFF_FFFF;
            return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
        endfunction

        function longint unsigned power_eleven(longint unsigned x);
            longint unsigned x2, x4, x8;
            x2 = mul_q32(x, x);
            x4 = mul_q32(x2, x2);
            x8 = mul_q32(x4, x4);
            return mul_q32(mul_q32(x8, x2), x);
        endfunction

        function longint unsigned power_five(longint unsigned m);
            longint unsigned m2, m4;
            m2 = mul_q32(m, m);
            m4 = mul_q32(m2, m2);
            return mul_q32(m4, m);
        endfunction

        function logic [7:0] tone_byte(logic [31:0] comp);
            longint unsigned p, one, k2, num, q, r, frac, t, uh, m, target, v, cand;
            logic carry;
            if (peak == 0)
                return 8'd0;
            p = comp;
            one = 64'd1 << FRAC_BITS;
            t = (p << 32) / (p + one);
            k2 = longint'(peak) * longint'(peak);
            num = p << FRAC_BITS;
            q = num / k2;
            r = num % k2;
            frac = 0;
            // Fraction bits of p/peak^2 by restoring long division.
            for (int i = 0; i < 32; i++)
            begin
                carry = r[63];
                r = r << 1;
                frac = frac << 1;
                if (carry || r >= k2)
                begin
                    r = r - k2;
                    frac = frac | 1;
                end
            end
            uh = q + 1;
            if (uh > (64'd1 << 32))
                uh = 64'd1 << 32;
            m = t * uh + ((t * frac) >> 32);
            if (m > (64'd1 << 33))
                m = 64'd1 << 33;
            target = power_five(m);
            v = 0;
            for (int i = 32; i >= 0; i--)
            begin
                cand = v | (64'd1 << i);
                if (power_eleven(cand) <= target)
                    v = cand;
            end
            if (v == 0)
                return 8'd0;
            v = ((v - 1) * 255) >> 32;
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        function void note_input(logic [95:0] data, logic [1:0] user, logic last);
            logic [31:0] comp;
            if (user[0] == hdrtm_pkg::FUNC_MEASURE)
            begin
                if (user[1])
                    peak = '0;
                for (int c = 0; c < 3; c++)
                begin
                    comp = data[32*c +: 32];
                    if (comp > peak)
                        peak = comp;
                end
            end
            else
                pending_pixels.insert(pending_pixels.size(),
                                      {last, tone_byte(data[95:64]),
                                       tone_byte(data[63:32]), tone_byte(data[31:0])});
        endfunction

        task check_result(logic [23:0] data, logic last);
            logic [24:0] want;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("unexpected pixel %h last %b", data, last));
                return;
            end
            want = pending_pixels.pop_front();
            if (data[7:0] !== want[7:0])
                report($sformatf("red %0d, expected %0d", data[7:0], want[7:0]));
            if (data[15:8] !== want[15:8])
                report($sformatf("green %0d, expected %0d", data[15:8], want[15:8]));
            if (data[23:16] !== want[23:16])
                report($sformatf("blue %0d, expected %0d", data[23:16], want[23:16]));
            if (last !== want[24])
                report($sformatf("tlast %b, expected %b", last, want[24]));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // red_in, green_in, blue_in
    logic [1:0]  s_tuser;   // func, first
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // red_out, green_out, blue_out
    logic        m_tlast;

    tone_scoreboard pixel_board;
    bit             hold_done;
    int             results_seen;
    int             idle_cycles;

    hdr_tone_map_gamma #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Both monitors sample at the edge, before the block's registers move.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pixel_board.note_input(s_tdata, s_tuser, s_tlast);
        if (rst_n && m_tvalid && m_tready)
        begin
            pixel_board.check_result(m_tdata, m_tlast);
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function logic [31:0] pick_component();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h000F_FFFF);
            2: return $urandom_range(0, 32'h0003_0000);
            3: return 32'd0;
            4: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    // Offers one transfer after a random gap and waits for it to be taken.
    task send_pixel(logic func, logic first, logic last,
                    logic [31:0] red, logic [31:0] green, logic [31:0] blue);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {first, func};
        s_tlast <= last;
        s_tdata <= {blue, green, red};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task send_frame();
        int n_measure;
        int n_map;
        n_measure = $urandom_range(1, 8);
        n_map = $urandom_range(1, 2);
        for (int i = 0; i < n_measure; i++)
            send_pixel(hdrtm_pkg::FUNC_MEASURE, i == 0, $urandom_range(0, 1),
                       pick_component(), pick_component(), pick_component());
        for (int i = 0; i < n_map; i++)
            send_pixel(hdrtm_pkg::FUNC_MAP, $urandom_range(0, 1), i == n_map - 1,
                       pick_component(), pick_component(), pick_component());
    endtask

    task drive_stimulus();
        int sent;
        // Zero peak after reset, first ignored in the map pass.
        send_pixel(hdrtm_pkg::FUNC_MAP, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd0);
        send_pixel(hdrtm_pkg::FUNC_MAP, 1'b0, 1'b1, 32'd0, 32'd1, 32'h8000_0000);
        send_pixel(hdrtm_pkg::FUNC_MEASURE, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0);
        send_pixel(hdrtm_pkg::FUNC_MAP, 1'b0, 1'b1, 32'h0001_0000, 32'd5, 32'hFFFF_FFFF);
        // Largest peak, then a small peak with components far above it.
        send_pixel(hdrtm_pkg::FUNC_MEASURE, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0,
                   32'h0000_0001);
        send_pixel(hdrtm_pkg::FUNC_MAP, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        send_pixel(hdrtm_pkg::FUNC_MEASURE, 1'b1, 1'b0, 32'd1, 32'd0, 32'd0);
        send_pixel(hdrtm_pkg::FUNC_MAP, 1'b0, 1'b0, 32'd1, 32'd2, 32'hFFFF_FFFF);
        send_pixel(hdrtm_pkg::FUNC_MEASURE, 1'b1, 1'b0, 32'h0000_4000, 32'h0001_0000,
                   32'h0000_8000);
        send_pixel(hdrtm_pkg::FUNC_MEASURE, 1'b0, 1'b1, 32'h0002_0000, 32'd3, 32'd0);
        send_pixel(hdrtm_pkg::FUNC_MAP, 1'b0, 1'b0, 32'h0002_0000, 32'h0001_0000,
                   32'h0002_0001);
        send_pixel(hdrtm_pkg::FUNC_MAP, 1'b0, 1'b1, 32'h0000_0100, 32'h0000_8000,
                   32'h0001_8000);
        sent = 12;
        while (sent < 1350)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_pixel($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom(), $urandom(), $urandom());
                sent++;
            end
            else
            begin
                send_frame();
                sent += 6;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Random ready gaps, plus one long hold-off that backs the queue up.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && results_seen >= 8)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        pixel_board = new();
        results_seen = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_stimulus();
        while (pixel_board.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (pixel_board.pending_pixels.size() != 0)
            pixel_board.report("pixels still expected at the end");
        if (pixel_board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hdrtm_pkg.sv
rtl/hdrtm_front.sv
rtl/hdrtm_fifo.sv
rtl/hdrtm_mul.sv
rtl/hdrtm_div.sv
rtl/hdrtm_back.sv
rtl/hdr_tone_map_gamma.sv
bench/hdr_tone_map_gamma_tb.sv
